// ===== design/cau_pkg.sv =====
// Shared constants, types and helpers of the complex arithmetic unit.
package cau_pkg;

  localparam int DW   = 16;                  // word width
  localparam int FB   = 12;                  // fraction bits
  localparam int QW   = DW;                  // quotient and root bits, one per step
  localparam int PW   = 2 * DW;              // product width
  localparam int SW   = PW + 1;              // sum of two products
  localparam int CLW  = PW + 3;              // width ahead of the clamp
  localparam int NW   = PW + FB + 2;         // scaled dividend
  localparam int DDW  = PW + 1;              // doubled divisor
  localparam int DSW  = DDW + QW;            // divisor at its top step
  localparam int RW   = (NW > DSW) ? NW : DSW;
  localparam int SQW  = PW + 2;              // root trial term
  localparam int NST  = QW + 5;              // pipeline stages

  localparam logic signed [CLW-1:0] RND  = CLW'((2 ** FB) / 2);
  localparam logic signed [CLW-1:0] HI_L = CLW'((2 ** (DW - 1)) - 1);
  localparam logic signed [CLW-1:0] LO_L = -HI_L - CLW'(1);

  typedef enum logic [3:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_MUL   = 4'd2,
    OP_DIV   = 4'd3,
    OP_EQ    = 4'd4,
    OP_NE    = 4'd5,
    OP_MAG   = 4'd6,
    OP_CONJ  = 4'd7,
    OP_SCALE = 4'd8
  } op_t;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_DZ  = 2'd1,
    ST_SAT = 2'd2
  } status_t;

  typedef logic signed [DW-1:0] word_t;

  typedef struct packed {
    logic  sat;
    word_t v;
  } clamp_t;

  typedef struct packed {
    word_t   re;
    word_t   im;
    logic    cmp;
    status_t st;
  } res_t;

  typedef struct packed {
    op_t                   kind;
    word_t                 ar;
    logic                  eq;
    logic signed [DW:0]    as_re;
    logic signed [DW:0]    as_im;
    logic signed [DW:0]    cj_im;
    logic signed [PW-1:0]  p_rr;
    logic signed [PW-1:0]  p_ii;
    logic signed [PW-1:0]  p_ri;
    logic signed [PW-1:0]  p_ir;
    logic signed [PW-1:0]  p_aa;
    logic signed [PW-1:0]  p_ai2;
    logic signed [PW-1:0]  p_br2;
    logic signed [PW-1:0]  p_bi2;
  } s1_t;

  typedef struct packed {
    op_t                   kind;
    word_t                 ar;
    logic                  eq;
    logic signed [DW:0]    as_re;
    logic signed [DW:0]    as_im;
    logic signed [DW:0]    cj_im;
    logic signed [PW-1:0]  p_rr;
    logic signed [PW-1:0]  p_ir;
    logic signed [SW-1:0]  mre;
    logic signed [SW-1:0]  mim;
    logic signed [SW-1:0]  nre;
    logic signed [SW-1:0]  nim;
    logic [PW-1:0]         den;
    logic [PW-1:0]         sq;
  } s2_t;

  typedef struct packed {
    logic [RW-1:0] rem;
    logic [QW-1:0] q;
    logic          neg;
    logic          ovf;
  } lane_t;

  typedef struct packed {
    op_t            kind;
    res_t           smp;
    logic           dz;
    logic [DDW-1:0] d;
    lane_t          lre;
    lane_t          lim;
    logic [PW-1:0]  sq;
    logic [DW-1:0]  root;
  } ds_t;

  function automatic clamp_t clamp(input logic signed [CLW-1:0] x);
    clamp_t c;
    c.sat = 1'b0;
    c.v   = DW'(x);
    if (x > HI_L) begin
      c.sat = 1'b1;
      c.v   = DW'(HI_L);
    end else if (x < LO_L) begin
      c.sat = 1'b1;
      c.v   = DW'(LO_L);
    end
    return c;
  endfunction

  // round to nearest, ties up, back to FB fraction bits
  function automatic logic signed [CLW-1:0] round_prod(input logic signed [CLW-1:0] x);
    logic signed [CLW-1:0] s;
    s = x + RND;
    return s >>> FB;
  endfunction

endpackage

// ===== design/complex_arithmetic_unit.sv =====
// Top level of the complex arithmetic unit: stage control and wiring.
// Pipelined complex ALU on signed Q3.12 words. Each word carries an opcode
// and operands A and B and yields one result word: add, subtract, multiply,
// divide, equal, not equal, magnitude of A, conjugate of A, or A scaled by
// b_re. It takes one word per cycle while in_stall is low and holds no state
// between words. Each opcode uses three front stages (products, sums,
// rounding and divider setup), one overflow-check stage, sixteen stages of
// the restoring divider and square root (one quotient and root bit each),
// and the output register. Each stage holds its word while the next is full
// and stalled, so bubbles close up and the input keeps flowing while a
// finished result waits, until every stage holds a word; then in_stall
// follows out_stall in the same cycle. Divide-by-zero returns zero with
// status 1; any clamped part gives status 2; unused opcodes return all zeros.
module complex_arithmetic_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [3:0]          kind,
  input  cau_pkg::word_t      a_re,
  input  cau_pkg::word_t      a_im,
  input  cau_pkg::word_t      b_re,
  input  cau_pkg::word_t      b_im,
  output logic                out_valid,
  input  logic                out_stall,
  output cau_pkg::word_t      res_re,
  output cau_pkg::word_t      res_im,
  output logic                compare_true,
  output logic [1:0]          status
);
  import cau_pkg::*;

  logic [NST-1:0] v;
  logic [NST-1:0] en;
  ds_t            q3;
  ds_t            qd;

  // a stage advances when it is empty or its successor advances
  always_comb begin
    en[NST-1] = !v[NST-1] || !out_stall;
    for (int i = NST - 2; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = v[NST-1];

  // valid bits travel with the words
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      for (int i = 1; i < NST; i++) begin
        if (en[i]) v[i] <= v[i-1];
      end
    end
  end

  cau_front u_front (
    .clk  (clk),
    .en   (en[2:0]),
    .kind (kind),
    .a_re (a_re),
    .a_im (a_im),
    .b_re (b_re),
    .b_im (b_im),
    .q3   (q3)
  );

  cau_divsqrt u_divsqrt (
    .clk   (clk),
    .en    (en[QW+3:3]),
    .d_in  (q3),
    .d_out (qd)
  );

  cau_back u_back (
    .clk          (clk),
    .en           (en[NST-1]),
    .d_in         (qd),
    .res_re       (res_re),
    .res_im       (res_im),
    .compare_true (compare_true),
    .status       (status)
  );

endmodule

// ===== design/cau_front.sv =====
// Front stages: products, sums, then simple results and divider setup.
module cau_front (
  input  logic                 clk,
  input  logic [2:0]           en,
  input  logic [3:0]           kind,
  input  cau_pkg::word_t       a_re,
  input  cau_pkg::word_t       a_im,
  input  cau_pkg::word_t       b_re,
  input  cau_pkg::word_t       b_im,
  output cau_pkg::ds_t         q3
);
  import cau_pkg::*;

  s1_t  s1, s1_next;
  s2_t  s2, s2_next;
  ds_t  q3_next;

  function automatic lane_t mk_lane(input logic signed [SW-1:0] num,
                                    input logic [PW-1:0] den);
    lane_t         l;
    logic [PW-1:0] mag;
    mag   = num[SW-1] ? PW'(-num) : PW'(num);
    l.rem = (RW'(mag) << (FB + 1)) + RW'(den);
    l.q   = '0;
    l.neg = num[SW-1];
    l.ovf = 1'b0;
    return l;
  endfunction

  // stage 1: all products, plus sums, conjugate and the equality test
  always_comb begin
    s1_next.kind  = op_t'(kind);
    s1_next.ar    = a_re;
    s1_next.eq    = (a_re == b_re) && (a_im == b_im);
    s1_next.as_re = (op_t'(kind) == OP_SUB) ? ((DW+1)'(a_re) - (DW+1)'(b_re))
                                            : ((DW+1)'(a_re) + (DW+1)'(b_re));
    s1_next.as_im = (op_t'(kind) == OP_SUB) ? ((DW+1)'(a_im) - (DW+1)'(b_im))
                                            : ((DW+1)'(a_im) + (DW+1)'(b_im));
    s1_next.cj_im = -((DW+1)'(a_im));
    s1_next.p_rr  = PW'(a_re) * PW'(b_re);
    s1_next.p_ii  = PW'(a_im) * PW'(b_im);
    s1_next.p_ri  = PW'(a_re) * PW'(b_im);
    s1_next.p_ir  = PW'(a_im) * PW'(b_re);
    s1_next.p_aa  = PW'(a_re) * PW'(a_re);
    s1_next.p_ai2 = PW'(a_im) * PW'(a_im);
    s1_next.p_br2 = PW'(b_re) * PW'(b_re);
    s1_next.p_bi2 = PW'(b_im) * PW'(b_im);
  end

  always_ff @(posedge clk) begin
    if (en[0]) s1 <= s1_next;
  end

  // stage 2: sums of products
  always_comb begin
    s2_next.kind  = s1.kind;
    s2_next.ar    = s1.ar;
    s2_next.eq    = s1.eq;
    s2_next.as_re = s1.as_re;
    s2_next.as_im = s1.as_im;
    s2_next.cj_im = s1.cj_im;
    s2_next.p_rr  = s1.p_rr;
    s2_next.p_ir  = s1.p_ir;
    s2_next.mre   = SW'(s1.p_rr) - SW'(s1.p_ii);
    s2_next.mim   = SW'(s1.p_ri) + SW'(s1.p_ir);
    s2_next.nre   = SW'(s1.p_rr) + SW'(s1.p_ii);
    s2_next.nim   = SW'(s1.p_ir) - SW'(s1.p_ri);
    s2_next.den   = PW'($unsigned(s1.p_br2)) + PW'($unsigned(s1.p_bi2));
    s2_next.sq    = PW'($unsigned(s1.p_aa)) + PW'($unsigned(s1.p_ai2));
  end

  always_ff @(posedge clk) begin
    if (en[1]) s2 <= s2_next;
  end

  // stage 3: finish the short operations, load divider and root lanes
  always_comb begin
    clamp_t cr, ci;
    cr = '0;
    ci = '0;
    q3_next.kind = s2.kind;
    q3_next.smp  = '0;
    unique case (s2.kind)
      OP_ADD, OP_SUB: begin
        cr = clamp(CLW'(s2.as_re));
        ci = clamp(CLW'(s2.as_im));
      end
      OP_MUL: begin
        cr = clamp(round_prod(CLW'(s2.mre)));
        ci = clamp(round_prod(CLW'(s2.mim)));
      end
      OP_SCALE: begin
        cr = clamp(round_prod(CLW'(s2.p_rr)));
        ci = clamp(round_prod(CLW'(s2.p_ir)));
      end
      OP_CONJ: begin
        cr = clamp(CLW'(s2.ar));
        ci = clamp(CLW'(s2.cj_im));
      end
      OP_EQ:   q3_next.smp.cmp = s2.eq;
      OP_NE:   q3_next.smp.cmp = !s2.eq;
      default: ;
    endcase
    q3_next.smp.re = cr.v;
    q3_next.smp.im = ci.v;
    q3_next.smp.st = (cr.sat || ci.sat) ? ST_SAT : ST_OK;
    q3_next.dz     = (s2.den == '0);
    q3_next.d      = {s2.den, 1'b0};
    q3_next.lre    = mk_lane(s2.nre, s2.den);
    q3_next.lim    = mk_lane(s2.nim, s2.den);
    q3_next.sq     = s2.sq;
    q3_next.root   = '0;
  end

  always_ff @(posedge clk) begin
    if (en[2]) q3 <= q3_next;
  end

endmodule

// ===== design/cau_divsqrt.sv =====
// Restoring divider and square root, one quotient and root bit per stage.
module cau_divsqrt (
  input  logic               clk,
  input  logic [cau_pkg::QW:0] en,
  input  cau_pkg::ds_t       d_in,
  output cau_pkg::ds_t       d_out
);
  import cau_pkg::*;

  ds_t st  [QW+1];
  ds_t nxt [QW+1];

  function automatic lane_t div_step(input lane_t l, input logic [DDW-1:0] d,
                                     input int b);
    lane_t         r;
    logic [RW-1:0] dsh;
    r   = l;
    dsh = RW'(d) << b;
    if (l.rem >= dsh) begin
      r.rem  = l.rem - dsh;
      r.q[b] = 1'b1;
    end
    return r;
  endfunction

  function automatic ds_t step(input ds_t x, input int b);
    ds_t            r;
    logic [SQW-1:0] t;
    r     = x;
    r.lre = div_step(x.lre, x.d, b);
    r.lim = div_step(x.lim, x.d, b);
    t     = (SQW'(x.root) << (b + 1)) + (SQW'(1) << (2 * b));
    if (SQW'(x.sq) >= t) begin
      r.sq      = PW'(SQW'(x.sq) - t);
      r.root[b] = 1'b1;
    end
    return r;
  endfunction

  // first stage flags a quotient too large for the word
  always_comb begin
    nxt[0]         = d_in;
    nxt[0].lre.ovf = d_in.lre.rem >= (RW'(d_in.d) << QW);
    nxt[0].lim.ovf = d_in.lim.rem >= (RW'(d_in.d) << QW);
    for (int k = 1; k <= QW; k++) begin
      nxt[k] = step(st[k-1], QW - k);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k <= QW; k++) begin
      if (en[k]) st[k] <= nxt[k];
    end
  end

  assign d_out = st[QW];

endmodule

// ===== design/cau_back.sv =====
// Output stage: finish division and magnitude, pick the result word.
module cau_back (
  input  logic            clk,
  input  logic            en,
  input  cau_pkg::ds_t    d_in,
  output cau_pkg::word_t  res_re,
  output cau_pkg::word_t  res_im,
  output logic            compare_true,
  output logic [1:0]      status
);
  import cau_pkg::*;

  res_t r_next;

  function automatic clamp_t fin_div(input lane_t l);
    clamp_t                c;
    logic signed [CLW-1:0] qs;
    qs = CLW'(l.q);
    if (l.neg) qs = -qs;
    c = clamp(qs);
    if (l.ovf) begin
      c.sat = 1'b1;
      c.v   = l.neg ? DW'(LO_L) : DW'(HI_L);
    end
    return c;
  endfunction

  always_comb begin
    clamp_t                cr, ci;
    logic signed [CLW-1:0] rr;
    cr = '0;
    ci = '0;
    rr = CLW'(d_in.root) + ((d_in.sq > PW'(d_in.root)) ? CLW'(1) : CLW'(0));
    r_next = d_in.smp;
    unique case (d_in.kind)
      OP_DIV: begin
        if (d_in.dz) begin
          r_next = '0;
          r_next.st = ST_DZ;
        end else begin
          cr = fin_div(d_in.lre);
          ci = fin_div(d_in.lim);
          r_next.re  = cr.v;
          r_next.im  = ci.v;
          r_next.cmp = 1'b0;
          r_next.st  = (cr.sat || ci.sat) ? ST_SAT : ST_OK;
        end
      end
      OP_MAG: begin
        cr = clamp(rr);
        r_next.re  = cr.v;
        r_next.im  = '0;
        r_next.cmp = 1'b0;
        r_next.st  = cr.sat ? ST_SAT : ST_OK;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_re       <= r_next.re;
      res_im       <= r_next.im;
      compare_true <= r_next.cmp;
      status       <= r_next.st;
    end
  end

endmodule

// ===== dv/tb_complex_arithmetic_unit.sv =====
// Self-checking testbench for the pipelined complex arithmetic unit.
`timescale 1ns / 1ps

module tb_complex_arithmetic_unit;
  import cau_pkg::*;

  // Let the drain wait well past the unit's latency.
  localparam int LATENCY = 21;
  localparam int N_RAND  = 800;
  localparam logic signed [15:0] MAXW = 16'sh7fff;
  localparam logic signed [15:0] MINW = -16'sh8000;
  localparam logic signed [15:0] ONE  = 16'sh1000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [3:0] kind = '0;
  word_t a_re = '0, a_im = '0, b_re = '0, b_im = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  word_t res_re, res_im;
  logic compare_true;
  logic [1:0] status;

  // One result word: what the unit sends back for each operand word.
  typedef struct packed {
    logic signed [15:0] re;
    logic signed [15:0] im;
    logic               cmp;
    logic [1:0]         st;
  } cres_t;

  // Directed row: operands, plus a typed-in expectation where one is obvious.
  typedef struct {
    logic [3:0] op;
    logic signed [15:0] ar, ai, br, bi;
    bit    known;
    cres_t want;
  } row_t;

  cres_t pending_results[$];
  int    mismatches = 0;
  bit    quiet = 1'b0;   // stretch with no idling on either side
  bit    stim_done = 1'b0;

  complex_arithmetic_unit DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

  // Saturate to the word range, flag a clamp.
  function automatic logic signed [15:0] sat16(input longint x, inout bit sat);
    if (x > 32767) begin sat = 1'b1; return MAXW; end
    if (x < -32768) begin sat = 1'b1; return MINW; end
    return x[15:0];
  endfunction

  // Round a 24-fraction-bit product back to 12, ties toward plus infinity.
  function automatic longint qround(input longint x);
    return (x + 2048) >>> 12;
  endfunction

  // Quotient of the scaled numerator, rounded to nearest, ties away from zero.
  function automatic longint qdiv(input longint num, input longint den);
    longint mag, q;
    mag = (num < 0 ? -num : num) <<< 12;
    q = (mag * 2 + den) / (den * 2);
    return num < 0 ? -q : q;
  endfunction

  // Integer square root rounded to nearest.
  function automatic longint root_round(input longint s);
    longint r;
    r = 0;
    for (int b = 31; b >= 0; b--)
      if ((r + (64'sd1 <<< b)) * (r + (64'sd1 <<< b)) <= s) r += 64'sd1 <<< b;
    if (s - r * r > r) r++;
    return r;
  endfunction

  function automatic cres_t complex_result(input logic [3:0] op,
                                           input logic signed [15:0] ar, ai, br, bi);
    cres_t o;
    bit    sat;
    longint den;
    o = '0;
    sat = 1'b0;
    case (op)
      OP_ADD: begin
        o.re = sat16(longint'(ar) + br, sat);
        o.im = sat16(longint'(ai) + bi, sat);
      end
      OP_SUB: begin
        o.re = sat16(longint'(ar) - br, sat);
        o.im = sat16(longint'(ai) - bi, sat);
      end
      OP_MUL: begin
        o.re = sat16(qround(longint'(ar) * br - longint'(ai) * bi), sat);
        o.im = sat16(qround(longint'(ar) * bi + longint'(ai) * br), sat);
      end
      OP_DIV: begin
        den = longint'(br) * br + longint'(bi) * bi;
        if (den == 0) o.st = ST_DZ;
        else begin
          o.re = sat16(qdiv(longint'(ar) * br + longint'(ai) * bi, den), sat);
          o.im = sat16(qdiv(longint'(ai) * br - longint'(ar) * bi, den), sat);
        end
      end
      OP_EQ:  o.cmp = (ar == br && ai == bi);
      OP_NE:  o.cmp = !(ar == br && ai == bi);
      OP_MAG: o.re = sat16(root_round(longint'(ar) * ar + longint'(ai) * ai), sat);
      OP_CONJ: begin
        o.re = ar;
        o.im = sat16(-longint'(ai), sat);
      end
      OP_SCALE: begin
        o.re = sat16(qround(longint'(ar) * br), sat);
        o.im = sat16(qround(longint'(ai) * br), sat);
      end
      default: ;
    endcase
    if (sat) o.st = ST_SAT;
    return o;
  endfunction

  // Idle at random before the word unless quiet, then hold it until accepted.
  task automatic send_word(input logic [3:0] op, input logic signed [15:0] ar, ai, br, bi);
    while (!quiet && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    kind <= op; a_re <= ar; a_im <= ai; b_re <= br; b_im <= bi;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(complex_result(op, ar, ai, br, bi));
    @(negedge clk);
  endtask

  // Random operand: mostly uniform, sometimes an extreme or a small value.
  function automatic logic signed [15:0] pick_word();
    case ($urandom_range(9))
      0: return MAXW;
      1: return MINW;
      2: return 16'($urandom_range(8191)) - 16'sd4096;
      3: return '0;
      default: return 16'($urandom);
    endcase
  endfunction

  // Stall the result side at random, except during the quiet stretch.
  always @(negedge clk)
    out_stall <= !quiet && ($urandom_range(99) < 13);

  // Compare each result word with the oldest expectation.
  always @(posedge clk) begin
    cres_t got, exp_r;
    if (!rst && out_valid && !out_stall) begin
      got = '{res_re, res_im, compare_true, status};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", got);
      end else begin
        exp_r = pending_results.pop_front();
        if (got !== exp_r) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: expected re=%0d im=%0d cmp=%0b st=%0d,",
                      " got re=%0d im=%0d cmp=%0b st=%0d"},
                     exp_r.re, exp_r.im, exp_r.cmp, exp_r.st,
                     got.re, got.im, got.cmp, got.st);
        end
      end
    end
  end

  row_t rows[$];

  // Typed-in rows check the predictor itself on the obvious cases.
  task automatic add_row(input logic [3:0] op, input logic signed [15:0] ar, ai, br, bi,
                         input bit known = 0, input cres_t want = '0);
    row_t r;
    r.op = op; r.ar = ar; r.ai = ai; r.br = br; r.bi = bi;
    r.known = known; r.want = want;
    rows.push_back(r);
  endtask

  initial begin
    int wait_cnt;
    cres_t p;
    add_row(OP_ADD, MAXW, MINW, ONE, -ONE, 1, '{MAXW, MINW, 1'b0, ST_SAT});
    add_row(OP_ADD, ONE, ONE, ONE, ONE, 1, '{16'sh2000, 16'sh2000, 1'b0, ST_OK});
    add_row(OP_SUB, MINW, MAXW, ONE, -ONE, 1, '{MINW, MAXW, 1'b0, ST_SAT});
    add_row(OP_MUL, ONE, ONE, ONE, -ONE);
    add_row(OP_MUL, MINW, MINW, MINW, MINW);
    add_row(OP_MUL, 16'sd1, 16'sd0, 16'sh0800, 16'sd0);
    add_row(OP_DIV, ONE, ONE, 16'sd0, 16'sd0, 1, '{16'sd0, 16'sd0, 1'b0, ST_DZ});
    add_row(OP_DIV, MAXW, MINW, 16'sd0, 16'sd0, 1, '{16'sd0, 16'sd0, 1'b0, ST_DZ});
    add_row(OP_DIV, ONE, 16'sd0, ONE, 16'sd0, 1, '{ONE, 16'sd0, 1'b0, ST_OK});
    add_row(OP_DIV, MAXW, MAXW, 16'sd1, 16'sd0);
    add_row(OP_DIV, 16'sd3, -16'sd5, 16'sd7, MINW);
    add_row(OP_EQ, ONE, -ONE, ONE, -ONE, 1, '{16'sd0, 16'sd0, 1'b1, ST_OK});
    add_row(OP_EQ, ONE, -ONE, ONE, ONE, 1, '{16'sd0, 16'sd0, 1'b0, ST_OK});
    add_row(OP_NE, MINW, MAXW, MINW, MAXW, 1, '{16'sd0, 16'sd0, 1'b0, ST_OK});
    add_row(OP_NE, MINW, MAXW, MAXW, MAXW, 1, '{16'sd0, 16'sd0, 1'b1, ST_OK});
    add_row(OP_MAG, 16'sh3000, 16'sh4000, 16'sd0, 16'sd0, 1,
            '{16'sh5000, 16'sd0, 1'b0, ST_OK});
    add_row(OP_MAG, MINW, MINW, MAXW, MAXW, 1, '{MAXW, 16'sd0, 1'b0, ST_SAT});
    add_row(OP_CONJ, ONE, ONE, 16'sd0, 16'sd0, 1, '{ONE, -ONE, 1'b0, ST_OK});
    add_row(OP_CONJ, MINW, MINW, MAXW, MAXW, 1, '{MINW, MAXW, 1'b0, ST_SAT});
    add_row(OP_SCALE, MAXW, MINW, ONE, MAXW, 1, '{MAXW, MINW, 1'b0, ST_OK});
    add_row(OP_SCALE, MAXW, MINW, MINW, 16'sd0);
    add_row(4'd9, MAXW, MAXW, MAXW, MAXW, 1, '0);
    add_row(4'd15, MINW, MINW, MINW, MINW, 1, '0);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      if (rows[i].known) begin
        p = complex_result(rows[i].op, rows[i].ar, rows[i].ai, rows[i].br, rows[i].bi);
        if (p !== rows[i].want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("row %0d: expected %h, predicted %h", i, rows[i].want, p);
        end
      end
      send_word(rows[i].op, rows[i].ar, rows[i].ai, rows[i].br, rows[i].bi);
    end

    // Random words; a stretch in the middle runs with no idling at all.
    for (int n = 0; n < N_RAND; n++) begin
      quiet = (n >= 300 && n < 450);
      send_word($urandom_range(99) < 5 ? 4'($urandom_range(15, 9)) : 4'($urandom_range(8)),
                pick_word(), pick_word(), pick_word(), pick_word());
    end
    quiet = 1'b0;
    in_valid <= 1'b0;

    // Drain: wait for every expected word, then keep watching for stray words.
    wait_cnt = 0;
    while (pending_results.size() != 0 && wait_cnt < 100_000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (2 * LATENCY) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
